### src/clcd_pkg.sv
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants of the 4-bit character LCD sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

  localparam int unsigned WaitW = 27;
  localparam int unsigned CfgW  = 16;

  typedef logic [WaitW-1:0] wait_t;
  typedef logic [CfgW-1:0]  cfg_word_t;
  typedef logic [1:0]       cfg_index_t;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_INSTR  = 2'd1,
    FUNC_CHAR   = 2'd2,
    FUNC_CURSOR = 2'd3
  } func_e;

  localparam cfg_index_t RegCharDelayMs   = 2'd0;
  localparam cfg_index_t RegNibbleWaitUs  = 2'd1;
  localparam cfg_index_t RegPowerOnWaitUs = 2'd2;

  localparam cfg_word_t ResetCharDelayMs   = 16'd0;
  localparam cfg_word_t ResetNibbleWaitUs  = 16'd2000;
  localparam cfg_word_t ResetPowerOnWaitUs = 16'd20000;

  localparam wait_t WaitA = 27'd5000;
  localparam wait_t WaitB = 27'd150;
  localparam wait_t WaitC = 27'd4000;

  localparam logic [9:0] UsPerMs = 10'd1000;

  localparam logic [3:0] NibWake = 4'h3;
  localparam logic [3:0] NibBus4 = 4'h2;

  localparam logic [7:0] CmdFuncSet   = 8'b0010_1000;
  localparam logic [7:0] CmdDisplayOn = 8'b0000_1111;
  localparam logic [7:0] CmdEntryMode = 8'b0000_0110;
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdSetDdram  = 8'b1000_0000;
  localparam logic [7:0] LineOneLast  = 8'd15;
  localparam logic [7:0] LineTwoSkip  = 8'd48;

  // Map a screen position to the set-DDRAM-address instruction.
  function automatic logic [7:0] cursor_cmd(input logic [5:0] pos);
    logic [7:0] a;
    a = {2'b00, pos} - 8'd1;
    if (a > LineOneLast) begin
      a = a + LineTwoSkip;
    end
    return a | CmdSetDdram;
  endfunction

endpackage

### src/char_lcd_four_bit_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_four_bit_sequencer
// 4-bit bus sequencer for an HD44780-style character LCD.
// ----------------------------------------------------------------------------
//  channel   | direction | transfer carries
//  s_axis    | in        | tuser: func; tdata: cmd_byte, cursor_pos
//  m_axis    | out       | tdata: lcd_data, lcd_rs, lcd_enable, busy_res, rejected
//  cfg       | in        | cfg_index_i selects register, cfg_data_i holds value
//
// One item per clock: each tick or command updates the sequencer state and its
// result lands in the output register. The input side stalls only while that
// register is full and not taken. Reset enters the power-on wait. The ms-to-us
// product of the character delay is formed when written.
// ----------------------------------------------------------------------------
module char_lcd_four_bit_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // cmd_byte[7:0], cursor_pos[13:8]
  input  logic [1:0]            s_axis_tuser,  // func[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // lcd_data, rs, enable, busy, rejected
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  clcd_pkg::cfg_index_t  cfg_index_i,
  input  clcd_pkg::cfg_word_t   cfg_data_i
);
  import clcd_pkg::*;

  typedef enum logic [3:0] {
    PH_POWER, PH_W1, PH_W2, PH_W3, PH_W4,
    PH_INIT0, PH_INIT1, PH_INIT2, PH_INIT3, PH_USER, PH_IDLE
  } phase_e;

  phase_e     phase_q, phase_d;
  wait_t      wait_q, wait_d;
  logic [7:0] pend_byte_q, pend_byte_d;
  logic       pend_rs_q, pend_rs_d;
  logic       low_next_q, low_next_d;
  logic [3:0] pin_data_q, pin_data_d;
  logic       pin_rs_q, pin_rs_d;
  logic       pin_en_q, pin_en_d;

  cfg_word_t  nib_wait_q;
  wait_t      char_wait_q;
  logic [7:0] res_q;
  logic       res_valid_q;

  logic       accept, cfg_wr, busy_now, rej;
  func_e      func;
  logic [7:0] cmd_byte;
  logic [5:0] cursor_pos;
  wait_t      wc, low_wait;

  assign func       = func_e'(s_axis_tuser);
  assign cmd_byte   = s_axis_tdata[7:0];
  assign cursor_pos = s_axis_tdata[13:8];

  assign s_axis_tready = !res_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_wr        = cfg_valid_i;
  assign busy_now      = (phase_q != PH_IDLE);
  assign wc            = (wait_q != '0) ? wait_q - wait_t'(1) : wait_q;
  assign low_wait      = wait_t'(nib_wait_q) + (pend_rs_q ? char_wait_q : '0);

  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    pend_byte_d = pend_byte_q;
    pend_rs_d   = pend_rs_q;
    low_next_d  = low_next_q;
    pin_data_d  = pin_data_q;
    pin_rs_d    = pin_rs_q;
    pin_en_d    = pin_en_q;
    rej         = 1'b0;
    if (func == FUNC_TICK) begin
      if (pin_en_q) begin
        pin_en_d = 1'b0;
      end else if (busy_now) begin
        wait_d = wc;
        if (wc == '0) begin
          unique case (phase_q)
            PH_POWER, PH_W1, PH_W2, PH_W3: begin
              pin_data_d = (phase_q == PH_W3) ? NibBus4 : NibWake;
              pin_rs_d   = 1'b0;
              pin_en_d   = 1'b1;
              wait_d     = (phase_q == PH_POWER) ? WaitA :
                           (phase_q == PH_W3) ? WaitC : WaitB;
              phase_d    = phase_e'(phase_q + 4'd1);
            end
            PH_W4: begin
              pend_byte_d = CmdFuncSet;
              pend_rs_d   = 1'b0;
              low_next_d  = 1'b1;
              phase_d     = PH_INIT0;
              pin_data_d  = CmdFuncSet[7:4];
              pin_rs_d    = 1'b0;
              pin_en_d    = 1'b1;
              wait_d      = wait_t'(nib_wait_q);
            end
            PH_INIT0, PH_INIT1, PH_INIT2, PH_INIT3, PH_USER: begin
              if (low_next_q) begin
                low_next_d = 1'b0;
                pin_data_d = pend_byte_q[3:0];
                pin_rs_d   = pend_rs_q;
                pin_en_d   = 1'b1;
                wait_d     = low_wait;
              end else if (phase_q == PH_INIT0 || phase_q == PH_INIT1 ||
                           phase_q == PH_INIT2) begin
                pend_byte_d = (phase_q == PH_INIT0) ? CmdDisplayOn :
                              (phase_q == PH_INIT1) ? CmdEntryMode : CmdClear;
                pend_rs_d   = 1'b0;
                low_next_d  = 1'b1;
                phase_d     = phase_e'(phase_q + 4'd1);
                pin_data_d  = pend_byte_d[7:4];
                pin_rs_d    = 1'b0;
                pin_en_d    = 1'b1;
                wait_d      = wait_t'(nib_wait_q);
              end else begin
                phase_d = PH_IDLE;
                wait_d  = '0;
              end
            end
            default: ;
          endcase
        end
      end
    end else if (busy_now) begin
      rej = 1'b1;
    end else begin
      unique case (func)
        FUNC_INSTR:  pend_byte_d = cmd_byte;
        FUNC_CHAR:   pend_byte_d = cmd_byte;
        default:     pend_byte_d = cursor_cmd(cursor_pos);
      endcase
      pend_rs_d  = (func == FUNC_CHAR);
      low_next_d = 1'b1;
      phase_d    = PH_USER;
      pin_data_d = pend_byte_d[7:4];
      pin_rs_d   = pend_rs_d;
      pin_en_d   = 1'b1;
      wait_d     = wait_t'(nib_wait_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_POWER;
      wait_q      <= wait_t'(ResetPowerOnWaitUs);
      pend_byte_q <= '0;
      pend_rs_q   <= 1'b0;
      low_next_q  <= 1'b0;
      pin_data_q  <= '0;
      pin_rs_q    <= 1'b0;
      pin_en_q    <= 1'b0;
      nib_wait_q  <= ResetNibbleWaitUs;
      char_wait_q <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        pend_byte_q <= pend_byte_d;
        pend_rs_q   <= pend_rs_d;
        low_next_q  <= low_next_d;
        pin_data_q  <= pin_data_d;
        pin_rs_q    <= pin_rs_d;
        pin_en_q    <= pin_en_d;
        res_q       <= {rej, (phase_d != PH_IDLE), pin_en_d, pin_rs_d, pin_data_d};
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
      if (cfg_wr && (cfg_index_i == RegPowerOnWaitUs) && (phase_q == PH_POWER)) begin
        wait_q <= wait_t'(cfg_data_i);
      end else if (accept) begin
        wait_q <= wait_d;
      end
      if (cfg_wr) begin
        unique case (cfg_index_i)
          RegCharDelayMs:  char_wait_q <= wait_t'(cfg_data_i) * wait_t'(UsPerMs);
          RegNibbleWaitUs: nib_wait_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q;

endmodule
